@@ hdl/rle_pkg.sv @@
// rle_pkg: shared constants and types for the run-length compressor.
// Used by the interfaces, the front end, the entry queue, the back end and the top level.
// No dependencies.
package rle_pkg;

    localparam int OUT_DEPTH  = 65536;
    localparam int WI_W       = 17;
    localparam int ELEM_W     = 16;
    localparam int BYTES_W    = 18;
    localparam int MAX_WR     = 4;
    localparam int CNT_W      = $clog2(MAX_WR + 1);
    localparam int WR_SEL_W   = $clog2(MAX_WR);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [WI_W-1:0]   WI_MAX     = {WI_W{1'b1}};
    localparam logic [WI_W-1:0]   OVF_LIMIT  = WI_W'(OUT_DEPTH);
    localparam logic [ELEM_W-1:0] SPAN_BYTE  = 16'd128;
    localparam logic [ELEM_W-1:0] SPAN_WORD  = 16'd32768;

    // one buffer write
    typedef struct packed {
        logic [ELEM_W-1:0]  out_index;
        logic [ELEM_W-1:0]  out_value;
        logic               out_last;
        logic [BYTES_W-1:0] out_bytes;
        logic               out_overflow;
    } t_wr;

    // all writes caused by one input element
    typedef struct packed {
        t_wr [MAX_WR-1:0] recs;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ hdl/rle_if.sv @@
// rle_in_if / rle_out_if: valid/ready channels for input elements and buffer writes.
// Depends on rle_pkg.
interface rle_in_if;
    import rle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] in_value;
    logic                     in_last;

    modport source (output valid, output in_value, output in_last, input ready);
    modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface rle_out_if;
    import rle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [ELEM_W-1:0] out_index;
    logic signed [ELEM_W-1:0] out_value;
    logic                     out_last;
    logic       [BYTES_W-1:0] out_bytes;
    logic                     out_overflow;

    modport source (output valid, output out_index, output out_value, output out_last,
                    output out_bytes, output out_overflow, input ready);
    modport sink   (input valid, input out_index, input out_value, input out_last,
                    input out_bytes, input out_overflow, output ready);
endinterface

@@ hdl/rle_front.sv @@
// rle_front: takes input elements, tracks span/run state, builds each element's writes.
// Depends on rle_pkg and rle_in_if.
module rle_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_wr_data,
    rle_in_if.sink             i_in,
    input  logic               i_q_full,
    output logic               o_push,
    output rle_pkg::t_entry    o_entry
);
    import rle_pkg::*;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_LIT   = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] ELEM_WORD = 2'd2;
    localparam logic [ELEM_W-1:0] HDR_BYTE = 16'd1;
    localparam logic [ELEM_W-1:0] HDR_WORD = 16'd2;

    typedef struct packed {
        logic [WI_W-1:0]   wi;
        logic [ELEM_W-1:0] shi;
        logic [ELEM_W-1:0] sc;
        logic [ELEM_W-1:0] ll;
        logic [ELEM_W-1:0] rc;
        logic [1:0]        ph;
        logic              wide;
    } t_st;

    t_st        r_st, n_st;
    logic [1:0] r_elem_bytes;
    t_entry     n_entry;
    logic       accept;

    function automatic logic [WI_W-1:0] f_inc(input logic [WI_W-1:0] w);
        return (w != WI_MAX) ? w + 1'b1 : w;
    endfunction

    function automatic void f_emit(inout t_entry e, input logic [ELEM_W-1:0] slot,
                                   input logic [ELEM_W-1:0] val, input logic [WI_W-1:0] wi);
        e.recs[e.cnt[WR_SEL_W-1:0]].out_index    = slot;
        e.recs[e.cnt[WR_SEL_W-1:0]].out_value    = val;
        e.recs[e.cnt[WR_SEL_W-1:0]].out_last     = 1'b0;
        e.recs[e.cnt[WR_SEL_W-1:0]].out_bytes    = '0;
        e.recs[e.cnt[WR_SEL_W-1:0]].out_overflow = (wi > OVF_LIMIT);
        e.cnt = e.cnt + 1'b1;
    endfunction

    function automatic void f_put(inout t_st s, inout t_entry e, input logic [ELEM_W-1:0] v,
                                  input logic [ELEM_W-1:0] ms);
        logic [WI_W-1:0] slot;
        if (s.sc >= ms) begin
            f_emit(e, s.shi, ms - 1'b1, s.wi);
            s.shi = s.wi[ELEM_W-1:0];
            s.wi  = f_inc(s.wi);
            s.sc  = '0;
        end
        slot = s.wi;
        s.wi = f_inc(s.wi);
        f_emit(e, slot[ELEM_W-1:0], v, s.wi);
        s.ll = v;
        s.sc = s.sc + 1'b1;
    endfunction

    function automatic void f_token(inout t_st s, inout t_entry e, input logic [ELEM_W-1:0] n);
        f_emit(e, s.wi[ELEM_W-1:0], ELEM_W'(0) - n, s.wi);
        s.wi = f_inc(s.wi);
        e.recs[e.cnt[WR_SEL_W-1:0] - 1'b1].out_overflow = (s.wi > OVF_LIMIT);
    endfunction

    function automatic void f_open(inout t_st s);
        s.shi = s.wi[ELEM_W-1:0];
        s.wi  = f_inc(s.wi);
        s.sc  = '0;
    endfunction

    function automatic void f_close(inout t_st s, inout t_entry e);
        f_emit(e, s.shi, s.sc - 1'b1, s.wi);
    endfunction

    always_comb begin
        t_st                s;
        t_entry             e;
        logic [ELEM_W-1:0]  ms;
        logic [ELEM_W-1:0]  x;
        logic [WR_SEL_W-1:0] li;
        s  = r_st;
        e  = '0;
        li = '0;
        if (s.ph != PH_LIT && s.ph != PH_RUN) begin
            s.wide = (r_elem_bytes == ELEM_WORD);
        end
        ms = s.wide ? SPAN_WORD : SPAN_BYTE;
        x  = s.wide ? i_in.in_value : {{8{i_in.in_value[7]}}, i_in.in_value[7:0]};
        if (s.ph != PH_LIT && s.ph != PH_RUN) begin
            f_emit(e, s.wi[ELEM_W-1:0], s.wide ? HDR_WORD : HDR_BYTE, s.wi);
            s.wi = f_inc(s.wi);
            e.recs[0].out_overflow = 1'b0;
            f_open(s);
            s.ph = PH_LIT;
            s.rc = '0;
            f_put(s, e, x, ms);
        end else if (s.ph == PH_LIT) begin
            if (x == s.ll) begin
                if (s.rc == '0) begin
                    s.rc = 16'd1;
                end else begin
                    f_close(s, e);
                    s.ph = PH_RUN;
                    s.rc = 16'd2;
                end
            end else begin
                if (s.rc == 16'd1) begin
                    f_put(s, e, s.ll, ms);
                end
                s.rc = '0;
                f_put(s, e, x, ms);
            end
        end else begin
            if (x == s.ll) begin
                s.rc = s.rc + 1'b1;
                if (s.rc >= ms) begin
                    f_token(s, e, ms);
                    s.rc = s.rc - ms;
                end
            end else begin
                if (s.rc >= 16'd2) begin
                    f_token(s, e, s.rc);
                end
                f_open(s);
                if (s.rc == 16'd1) begin
                    f_put(s, e, s.ll, ms);
                end
                s.rc = '0;
                s.ph = PH_LIT;
                f_put(s, e, x, ms);
            end
        end
        if (i_in.in_last) begin
            if (s.ph == PH_LIT) begin
                if (s.rc == 16'd1) begin
                    f_put(s, e, s.ll, ms);
                end
                f_close(s, e);
            end else if (s.ph == PH_RUN) begin
                if (s.rc >= 16'd2) begin
                    f_token(s, e, s.rc);
                end else if (s.rc == 16'd1) begin
                    f_open(s);
                    f_put(s, e, s.ll, ms);
                    f_close(s, e);
                end
            end
            if (e.cnt != '0) begin
                li = e.cnt[WR_SEL_W-1:0] - 1'b1;
                e.recs[li].out_last     = 1'b1;
                e.recs[li].out_bytes    = s.wide ? {s.wi, 1'b0} : {1'b0, s.wi};
                e.recs[li].out_overflow = (s.wi > OVF_LIMIT);
            end
            s      = '0;
            s.wide = r_st.wide;
        end
        n_st    = s;
        n_entry = e;
    end

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept && (n_entry.cnt != '0);
    assign o_entry    = n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= '0;
            r_elem_bytes <= 2'd1;
        end else begin
            if (accept) begin
                r_st <= n_st;
            end
            if (i_cfg_wr_en) begin
                r_elem_bytes <= i_cfg_wr_data;
            end
        end
    end

endmodule

@@ hdl/rle_fifo.sv @@
// rle_fifo: short queue of per-element write groups between front and back end.
// Depends on rle_pkg.
module rle_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rle_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output rle_pkg::t_entry    o_entry,
    output rle_pkg::t_q_stat   o_stat
);
    import rle_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/rle_back.sv @@
// rle_back: unpacks queued write groups and drives one buffer write per transfer.
// Depends on rle_pkg and rle_out_if.
module rle_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rle_pkg::t_entry    i_entry,
    input  logic               i_q_empty,
    output logic               o_pop,
    rle_out_if.source          o_out
);
    import rle_pkg::*;

    t_entry              r_ent;
    logic [WR_SEL_W-1:0] r_pos;
    logic                r_busy;
    t_wr                 r_out;
    logic                r_out_valid;
    logic                can_load;
    logic                adv;
    logic                last_of;
    logic                fetch;

    assign can_load = !r_out_valid || o_out.ready;
    assign adv      = r_busy && can_load;
    assign last_of  = ({1'b0, r_pos} + 1'b1) == r_ent.cnt;
    assign fetch    = !r_busy || (adv && last_of);
    assign o_pop    = fetch && !i_q_empty;

    assign o_out.valid        = r_out_valid;
    assign o_out.out_index    = r_out.out_index;
    assign o_out.out_value    = r_out.out_value;
    assign o_out.out_last     = r_out.out_last;
    assign o_out.out_bytes    = r_out.out_bytes;
    assign o_out.out_overflow = r_out.out_overflow;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= r_ent.recs[r_pos];
        end
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fetch) begin
                r_busy <= !i_q_empty;
                r_pos  <= '0;
            end else if (adv) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

endmodule

@@ hdl/rle_span_run_compressor.sv @@
// rle_span_run_compressor: top level of the span/run length compressor.
// Depends on rle_pkg, rle_if, rle_front, rle_fifo, rle_back.
//
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      in_value[15:0], in_last
//  o_out     out  valid/ready      out_index, out_value, out_last, out_bytes, out_overflow
//  cfg       in   i_cfg_wr_en      i_cfg_wr_data[1:0] (element size)
//
// One element is taken per cycle while the four-deep group queue has room.
// Each element yields 0 to 4 writes; the back end drives one write per cycle while o_out
// is ready, so elements can be taken while earlier writes are still queued.
// Output is registered; a stalled o_out fills the queue, then drops i_in.ready.
// Synchronous active-low reset returns the block to the start of a block.
module rle_span_run_compressor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    rle_in_if.sink     i_in,
    rle_out_if.source  o_out
);
    import rle_pkg::*;

    t_entry  front_entry;
    t_entry  q_entry;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    rle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_full      (q_stat.full),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    rle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_stat  (q_stat)
    );

    rle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (q_entry),
        .i_q_empty (q_stat.empty),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

@@ bench/rle_write_checker.sv @@
`timescale 1ns / 100ps
// rle_write_checker: predicts the buffer writes of rle_span_run_compressor and
// checks the o_out transfers against them. Depends on rle_pkg and rle_if.
module rle_write_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    rle_in_if          in_mon,
    rle_out_if         out_mon,
    output int         o_fail_count,
    output int         o_pending
);
    import rle_pkg::*;

    typedef enum logic [1:0] {PH_START, PH_LIT, PH_RUN} t_phase;

    localparam int unsigned SLOT_SAT = 131071;

    logic [1:0]  elem_reg;
    logic        wide;
    t_phase      phase;
    int unsigned wr_idx;
    int unsigned head_idx;
    int unsigned span_cnt;
    int unsigned run_cnt;
    logic [15:0] prev_lit;
    int          fails;

    t_wr step_q[$];
    t_wr want_q[$];

    function automatic int unsigned span_limit();
        return wide ? 32768 : 128;
    endfunction

    function automatic int unsigned take_slot();
        int unsigned s;
        s = wr_idx;
        if (wr_idx < SLOT_SAT) wr_idx++;
        return s;
    endfunction

    function automatic void push_write(input int unsigned slot, input logic [15:0] value);
        t_wr w;
        w.out_index    = slot[15:0];
        w.out_value    = value;
        w.out_last     = 1'b0;
        w.out_bytes    = '0;
        w.out_overflow = (wr_idx > OUT_DEPTH);
        step_q.push_back(w);
    endfunction

    function automatic void push_token(input int unsigned n);
        t_wr w;
        push_write(wr_idx, 16'(32'h10000 - n));
        void'(take_slot());
        w = step_q.pop_back();
        w.out_overflow = (wr_idx > OUT_DEPTH);
        step_q.push_back(w);
    endfunction

    function automatic void add_literal(input logic [15:0] v);
        int unsigned slot;
        if (span_cnt >= span_limit()) begin
            push_write(head_idx, 16'(span_limit() - 1));
            head_idx = take_slot();
            span_cnt = 0;
        end
        slot = take_slot();
        push_write(slot, v);
        prev_lit = v;
        span_cnt++;
    endfunction

    function automatic void close_span();
        push_write(head_idx, 16'(span_cnt - 1));
    endfunction

    function automatic void open_span();
        head_idx = take_slot();
        span_cnt = 0;
    endfunction

    function automatic void clear_block();
        wr_idx   = 0;
        head_idx = 0;
        span_cnt = 0;
        prev_lit = '0;
        run_cnt  = 0;
        phase    = PH_START;
    endfunction

    function automatic void end_block();
        t_wr w;
        if (phase == PH_LIT) begin
            if (run_cnt == 1) add_literal(prev_lit);
            close_span();
        end else if (phase == PH_RUN) begin
            if (run_cnt >= 2) begin
                push_token(run_cnt);
            end else if (run_cnt == 1) begin
                open_span();
                add_literal(prev_lit);
                close_span();
            end
        end
        if (step_q.size() > 0) begin
            w = step_q.pop_back();
            w.out_last     = 1'b1;
            w.out_bytes    = 18'(wr_idx * (wide ? 2 : 1));
            w.out_overflow = (wr_idx > OUT_DEPTH);
            step_q.push_back(w);
        end
        clear_block();
    endfunction

    function automatic void predict_element(input logic [15:0] raw, input logic lst);
        logic [15:0] x;
        int unsigned slot;
        step_q.delete();
        if (phase != PH_LIT && phase != PH_RUN) begin
            wide = (elem_reg == 2'd2);
            slot = take_slot();
            push_write(slot, wide ? 16'd2 : 16'd1);
            open_span();
            phase   = PH_LIT;
            run_cnt = 0;
            x = wide ? raw : {{8{raw[7]}}, raw[7:0]};
            add_literal(x);
        end else begin
            x = wide ? raw : {{8{raw[7]}}, raw[7:0]};
            if (phase == PH_LIT) begin
                if (x == prev_lit) begin
                    if (run_cnt == 0) begin
                        run_cnt = 1;
                    end else begin
                        close_span();
                        phase   = PH_RUN;
                        run_cnt = 2;
                    end
                end else begin
                    if (run_cnt == 1) add_literal(prev_lit);
                    run_cnt = 0;
                    add_literal(x);
                end
            end else begin
                if (x == prev_lit) begin
                    run_cnt++;
                    if (run_cnt >= span_limit()) begin
                        push_token(span_limit());
                        run_cnt -= span_limit();
                    end
                end else begin
                    if (run_cnt >= 2) push_token(run_cnt);
                    open_span();
                    if (run_cnt == 1) add_literal(prev_lit);
                    run_cnt = 0;
                    phase   = PH_LIT;
                    add_literal(x);
                end
            end
        end
        if (lst) end_block();
        foreach (step_q[k]) want_q.push_back(step_q[k]);
    endfunction

    function automatic void check_write(input t_wr got);
        t_wr exp;
        if (want_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected write: idx=%0d val=%h last=%b bytes=%0d ovf=%b",
                         got.out_index, got.out_value, got.out_last, got.out_bytes,
                         got.out_overflow);
            return;
        end
        exp = want_q.pop_front();
        if (got.out_index != exp.out_index || got.out_value != exp.out_value ||
            got.out_last != exp.out_last || got.out_bytes != exp.out_bytes ||
            got.out_overflow != exp.out_overflow) begin
            fails++;
            if (fails <= 10)
                $display("write mismatch: exp %0d %h %b %0d %b / got %0d %h %b %0d %b",
                         exp.out_index, exp.out_value, exp.out_last, exp.out_bytes,
                         exp.out_overflow, got.out_index, got.out_value, got.out_last,
                         got.out_bytes, got.out_overflow);
        end
    endfunction

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
        elem_reg     = 2'd1;
        wide         = 1'b0;
        clear_block();
    end

    always @(posedge i_clk) begin
        t_wr got;
        if (!i_rst_n) begin
            elem_reg = 2'd1;
            wide     = 1'b0;
            clear_block();
            want_q.delete();
        end else begin
            if (in_mon.valid && in_mon.ready)
                predict_element(in_mon.in_value, in_mon.in_last);
            if (i_cfg_wr_en) elem_reg = i_cfg_wr_data;
            if (out_mon.valid && out_mon.ready) begin
                got.out_index    = out_mon.out_index;
                got.out_value    = out_mon.out_value;
                got.out_last     = out_mon.out_last;
                got.out_bytes    = out_mon.out_bytes;
                got.out_overflow = out_mon.out_overflow;
                check_write(got);
            end
        end
        o_fail_count <= fails;
        o_pending    <= want_q.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// testbench: drives elements and mode writes into rle_span_run_compressor and
// gives the verdict. Depends on rle_pkg, rle_if and rle_write_checker.
module testbench;
    import rle_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYC  = 16;
    localparam int HOLD_CYC    = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [1:0] i_cfg_wr_data;
    int         fail_count;
    int         pending;
    int         cycle_cnt;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic       hold_req;
    int         hold_left;

    logic [15:0] corner_vals [8] = '{16'h0000, 16'h0001, 16'h007F, 16'h0080,
                                     16'h00FF, 16'h7FFF, 16'h8000, 16'hFFFF};
    logic [1:0]  mode_seq [8]    = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd1};
    int          send_tab [4]    = '{0, 86, 0, 6};
    int          recv_tab [4]    = '{0, 0, 86, 6};

    rle_in_if  in_ch ();
    rle_out_if out_ch ();

    rle_span_run_compressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    rle_write_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_elem(input logic [15:0] v, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_value <= v;
        in_ch.in_last  <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_run(input logic [15:0] v, input int n, input logic end_blk);
        for (int k = 0; k < n; k++) send_elem(v, end_blk && (k == n - 1));
    endtask

    // random blocks built from runs, with some unrelated elements mixed in
    task automatic run_traffic(input int n_items);
        logic [15:0] cur;
        int          run_left;
        int          sent;
        cur      = 16'($urandom);
        run_left = 0;
        sent     = 0;
        while (sent < n_items || run_left > 0) begin
            if ($urandom_range(7) == 0) begin
                send_elem(16'($urandom), 1'($urandom_range(1)));
            end else begin
                if (run_left == 0) begin
                    case ($urandom_range(4))
                        0: cur = 16'($urandom);
                        1: cur = corner_vals[$urandom_range(7)];
                        2: cur = {8'($urandom), cur[7:0]};
                        3: cur = cur + 16'd1;
                        default: ;
                    endcase
                    if ($urandom_range(9) == 0)
                        run_left = $urandom_range(6, 9);
                    else if ($urandom_range(9) < 6)
                        run_left = 1;
                    else
                        run_left = $urandom_range(2, 5);
                end
                send_elem(cur, $urandom_range(11) == 0);
                run_left--;
            end
            sent++;
        end
        send_elem(16'($urandom), 1'b1);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 2'd0;
        in_ch.valid    = 1'b0;
        in_ch.in_value = '0;
        in_ch.in_last  = 1'b0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte mode
        write_mode(2'd1);
        send_elem(16'h007F, 1'b1);
        send_elem(16'h0080, 1'b0);
        send_elem(16'hFF80, 1'b0);      // equal after sign extension
        send_elem(16'h0001, 1'b1);
        send_run(16'd5, 3, 1'b1);       // run closing the block
        send_run(16'd9, 2, 1'b1);       // single leftover repeat at end
        send_run(16'd2, 3, 1'b0);
        send_run(16'd7, 2, 1'b0);
        send_elem(16'd8, 1'b1);
        settle();

        // directed: word mode
        write_mode(2'd2);
        send_elem(16'h8000, 1'b0);
        send_run(16'h7FFF, 3, 1'b0);
        send_elem(16'hFFFF, 1'b0);
        send_elem(16'h1234, 1'b0);
        send_elem(16'h5634, 1'b1);      // differs only in the upper byte
        settle();

        // random traffic under four idle patterns, mode changed in between
        for (int p = 0; p < 8; p++) begin
            send_idle_pct  = send_tab[p / 2];
            recv_stall_pct = recv_tab[p / 2];
            write_mode(mode_seq[p]);
            if (p == 0) hold_req = 1'b1;
            run_traffic(9);
            settle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
